[rtl/assert_macros.svh]
// Assertion macros included by ait_back; clock is clk_i, reset is rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define AIT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Same-cycle implication outside reset.
`define AIT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/ait_pkg.sv]
// Types and constants of the associative ignore table.
`default_nettype none

package ait_pkg;

  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned UOP_W       = 8;
  localparam int unsigned HANDLE_W    = 8;
  localparam int unsigned SLOT_W      = 2;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned OCC_W       = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_LOOKUP,
    OP_NOP
  } op_e;

  typedef enum logic {
    S_FETCH,
    S_EXEC
  } seq_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [ADDR_W-1:0]   address;
    logic [UOP_W-1:0]    uop_index;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot_tag;
  } in_item_t;

  typedef struct packed {
    logic                ok;
    logic [HANDLE_W-1:0] found_handle;
    logic [SLOT_W-1:0]   found_slot;
    logic [OCC_W-1:0]    occupancy;
  } result_t;

  typedef struct packed {
    op_e                 op;
    logic [ADDR_W-1:0]   address;
    logic [UOP_W-1:0]    uop_index;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot_tag;
  } entry_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot_tag;
  } payload_t;

endpackage

`default_nettype wire

[rtl/ait_queue.sv]
// Short FIFO of fixed depth used between the block's parts.
`default_nettype none

module ait_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import ait_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(QUEUE_DEPTH);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/ait_front.sv]
// Front end: accepts input beats and decodes the command into an operation.
`default_nettype none

module ait_front (
  input  logic              push_i,
  input  ait_pkg::in_item_t item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output ait_pkg::entry_t   q_entry_o
);
  import ait_pkg::*;

  op_e op;

  always_comb begin
    case (item_i.cmd)
      CMD_INSERT: op = OP_INSERT;
      CMD_REMOVE: op = OP_REMOVE;
      CMD_LOOKUP: op = OP_LOOKUP;
      default:    op = OP_NOP;
    endcase
  end

  assign q_push_o            = push_i && !q_full_i;
  assign q_entry_o.op        = op;
  assign q_entry_o.address   = item_i.address;
  assign q_entry_o.uop_index = item_i.uop_index;
  assign q_entry_o.handle    = item_i.handle;
  assign q_entry_o.slot_tag  = item_i.slot_tag;

endmodule

`default_nettype wire

[rtl/ait_back.sv]
// Back end: key table, parallel compare, priority select and table update.
`default_nettype none

`include "assert_macros.svh"

module ait_back #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ait_pkg::entry_t  q_entry_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  input  logic             out_full_i,
  output logic             out_push_o,
  output ait_pkg::result_t out_result_o
);
  import ait_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(TABLE_ENTRIES);

  seq_state_e               state_q, state_d;
  entry_t                   cur_q;
  logic [TABLE_ENTRIES-1:0] match_q, match_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]         used_q, used_d;
  logic                     pend_q, pend_d;

  logic [ADDR_W-1:0]        key_addr_q [TABLE_ENTRIES];
  logic [UOP_W-1:0]         key_uop_q  [TABLE_ENTRIES];
  payload_t                 pay_mem    [TABLE_ENTRIES];
  payload_t                 rd_q;

  logic                     res_ok_q, res_hit_q;
  logic [OCC_W-1:0]         res_occ_q;

  logic                     load_cur, exec_fire, wr_en, rd_en, exec_ok, lookup_hit;
  logic [IDX_W-1:0]         match_idx, free_idx;
  logic                     hit;

  // Compare the incoming key against every entry at once.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_d[i] = valid_q[i] && (key_addr_q[i] == q_entry_i.address) &&
                   (key_uop_q[i] == q_entry_i.uop_index);
    end
  end

  // Lowest-numbered match and lowest-numbered free entry.
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        match_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit = |match_q;

  always_comb begin
    state_d    = state_q;
    q_pop_o    = 1'b0;
    load_cur   = 1'b0;
    exec_fire  = 1'b0;
    valid_d    = valid_q;
    used_d     = used_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    exec_ok    = 1'b0;
    lookup_hit = 1'b0;
    pend_d     = 1'b0;
    case (state_q)
      S_FETCH: begin
        if (!q_empty_i) begin
          q_pop_o  = 1'b1;
          load_cur = 1'b1;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        // Hold until the result queue has room for this beat.
        if (!out_full_i) begin
          exec_fire = 1'b1;
          pend_d    = 1'b1;
          state_d   = S_FETCH;
          case (cur_q.op)
            OP_INSERT: begin
              if (used_q < CntMax) begin
                valid_d[free_idx] = 1'b1;
                used_d            = used_q + 1'b1;
                wr_en             = 1'b1;
                exec_ok           = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                valid_d[match_idx] = 1'b0;
                used_d             = used_q - 1'b1;
                exec_ok            = 1'b1;
              end
            end
            OP_LOOKUP: begin
              rd_en      = hit;
              exec_ok    = hit;
              lookup_hit = hit;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = S_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FETCH;
      valid_q <= '0;
      used_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      used_q  <= used_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cur) begin
      cur_q   <= q_entry_i;
      match_q <= match_d;
    end
    if (wr_en) begin
      key_addr_q[free_idx] <= cur_q.address;
      key_uop_q[free_idx]  <= cur_q.uop_index;
    end
    if (exec_fire) begin
      res_ok_q  <= exec_ok;
      res_hit_q <= lookup_hit;
      res_occ_q <= OCC_W'(used_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pay_mem[free_idx] <= '{handle: cur_q.handle, slot_tag: cur_q.slot_tag};
    end
    if (rd_en) begin
      rd_q <= pay_mem[match_idx];
    end
  end

  assign out_push_o                = pend_q;
  assign out_result_o.ok           = res_ok_q;
  assign out_result_o.found_handle = res_hit_q ? rd_q.handle : '0;
  assign out_result_o.found_slot   = res_hit_q ? rd_q.slot_tag : '0;
  assign out_result_o.occupancy    = res_occ_q;

  `AIT_ASSERT_ALWAYS(a_used_matches_valid, $countones(valid_q) == used_q, "count off valid bits")
  `AIT_ASSERT_IMPL(a_push_has_room, pend_q, !out_full_i, "result pushed into a full queue")
  `AIT_ASSERT_IMPL(a_exec_after_fetch, state_q == S_EXEC && $past(state_q) == S_FETCH,
                   $past(q_pop_o), "execute entered without a popped beat")

endmodule

`default_nettype wire

[rtl/associative_ignore_table_unit.sv]
// Associative ignore table: front decode, command queue, table back end, result queue.
//
// Input channel: drive in_item_i and raise push; a beat is taken at a rising
// edge with push high and full low. Commands are insert, remove and lookup;
// any other code leaves the table as it is and reports a failed result.
// Result channel: while empty is low the oldest result sits on result_o; it is
// taken at a rising edge with pop high. Every input beat gives one result.
// The back end handles one item at a time with a fetch/execute sequencer
// (register the parallel key compare, then priority select and update the
// table), so it takes no new item from the command queue before the last
// one has executed.
// A two-entry queue sits on each side, so input beats are still taken while
// a finished result waits. If pop stays low, the result queue fills, the back
// end holds its current item, and then the command queue fills and full rises.
// Reset clears all valid bits, the occupancy count and both queues at once;
// the block takes input beats as soon as reset is released.
`default_nettype none

module associative_ignore_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  ait_pkg::in_item_t in_item_i,
  output logic              empty,
  input  logic              pop,
  output ait_pkg::result_t  result_o
);
  import ait_pkg::*;

  logic    cq_push, cq_empty, bk_pop, rq_full, rq_push;
  entry_t  cq_in, cq_out;
  result_t rq_in;

  ait_front u_front (
    .push_i    (push),
    .item_i    (in_item_i),
    .q_full_i  (full),
    .q_push_o  (cq_push),
    .q_entry_o (cq_in)
  );

  ait_queue #(
    .WIDTH ($bits(entry_t))
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .data_i  (cq_in),
    .full_o  (full),
    .pop_i   (bk_pop),
    .data_o  (cq_out),
    .empty_o (cq_empty)
  );

  ait_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_entry_i    (cq_out),
    .q_empty_i    (cq_empty),
    .q_pop_o      (bk_pop),
    .out_full_i   (rq_full),
    .out_push_o   (rq_push),
    .out_result_o (rq_in)
  );

  ait_queue #(
    .WIDTH ($bits(result_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_in),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the associative ignore table unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ait_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SEG_ITEMS     = 40;
  localparam int unsigned SEG_COUNT     = 14;
  localparam int unsigned POOL_KEYS     = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_MIXED,
    MIX_DRAIN,
    MIX_ANY
  } mix_mode_e;

  // Table predictor plus queue of results still owed by the block.
  class ignore_table_scoreboard #(int unsigned ENTRIES = 32);
    bit                  entry_valid [ENTRIES];
    logic [ADDR_W-1:0]   entry_addr  [ENTRIES];
    logic [UOP_W-1:0]    entry_uop   [ENTRIES];
    logic [HANDLE_W-1:0] entry_handle[ENTRIES];
    logic [SLOT_W-1:0]   entry_slot  [ENTRIES];
    logic [31:0]         used_count;
    result_t             owed_results[$];
    int unsigned         mismatches;

    function new();
      foreach (entry_valid[i]) entry_valid[i] = 1'b0;
      used_count = '0;
      mismatches = 0;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function int find_match(logic [ADDR_W-1:0] addr, logic [UOP_W-1:0] uop);
      for (int i = 0; i < ENTRIES; i++) begin
        if (entry_valid[i] && entry_addr[i] == addr && entry_uop[i] == uop) return i;
      end
      return -1;
    endfunction

    function result_t predict_result(in_item_t item);
      result_t res;
      int      idx;
      bit      placed;
      res = '0;
      placed = 1'b0;
      case (item.cmd)
        CMD_INSERT: begin
          if (used_count < ENTRIES) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (!placed && !entry_valid[i]) begin
                entry_valid[i]  = 1'b1;
                entry_addr[i]   = item.address;
                entry_uop[i]    = item.uop_index;
                entry_handle[i] = item.handle;
                entry_slot[i]   = item.slot_tag;
                used_count++;
                placed = 1'b1;
              end
            end
            res.ok = placed;
          end
        end
        CMD_REMOVE: begin
          if (used_count != 0) begin
            idx = find_match(item.address, item.uop_index);
            if (idx >= 0) begin
              entry_valid[idx] = 1'b0;
              used_count--;
              res.ok = 1'b1;
            end
          end
        end
        CMD_LOOKUP: begin
          idx = find_match(item.address, item.uop_index);
          if (idx >= 0) begin
            res.ok           = 1'b1;
            res.found_handle = entry_handle[idx];
            res.found_slot   = entry_slot[idx];
          end
        end
        default: ;
      endcase
      res.occupancy = used_count[OCC_W-1:0];
      return res;
    endfunction

    function void note_command(in_item_t item);
      owed_results.push_back(predict_result(item));
    endfunction

    task check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result %0h", got));
      end else begin
        want = owed_results.pop_front();
        if (got.ok !== want.ok)
          report($sformatf("ok got %0b expected %0b", got.ok, want.ok));
        if (got.found_handle !== want.found_handle)
          report($sformatf("found_handle got %0h expected %0h",
                           got.found_handle, want.found_handle));
        if (got.found_slot !== want.found_slot)
          report($sformatf("found_slot got %0h expected %0h",
                           got.found_slot, want.found_slot));
        if (got.occupancy !== want.occupancy)
          report($sformatf("occupancy got %0d expected %0d",
                           got.occupancy, want.occupancy));
      end
    endtask

    task flag_leftovers();
      while (owed_results.size() != 0) begin
        report($sformatf("result never arrived, expected %0h", owed_results.pop_front()));
      end
    endtask

    function int unsigned owed_count();
      return owed_results.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  logic     full;
  in_item_t in_item;
  logic     empty;
  logic     pop;
  result_t  result_o;

  ignore_table_scoreboard #(TABLE_ENTRIES) sb;

  logic [ADDR_W-1:0] pool_addr[POOL_KEYS];
  logic [UOP_W-1:0]  pool_uop [POOL_KEYS];
  bit                tx_burst;

  associative_ignore_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_item_i(in_item),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_item_t make_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                         logic [UOP_W-1:0] uop, logic [HANDLE_W-1:0] hnd,
                                         logic [SLOT_W-1:0] slot);
    in_item_t item;
    item.cmd       = cmd;
    item.address   = addr;
    item.uop_index = uop;
    item.handle    = hnd;
    item.slot_tag  = slot;
    return item;
  endfunction

  // Offer one beat and hold it until the block takes it.
  task automatic send_command(in_item_t item);
    int unsigned gap;
    gap = tx_burst ? 0 : idle_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= item;
    do @(posedge clk_i); while (full);
    sb.note_command(item);
  endtask

  function automatic in_item_t random_command(mix_mode_e mode);
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [UOP_W-1:0]  uop;
    int unsigned       r;
    int unsigned       k;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      cmd = CMD_UNUSED;
    end else begin
      r = $urandom_range(0, 99);
      case (mode)
        MIX_FILL:  cmd = (r < 85) ? CMD_INSERT : (r < 93) ? CMD_LOOKUP : CMD_REMOVE;
        MIX_DRAIN: cmd = (r < 15) ? CMD_INSERT : (r < 80) ? CMD_REMOVE : CMD_LOOKUP;
        MIX_MIXED: cmd = (r < 40) ? CMD_INSERT : (r < 70) ? CMD_REMOVE : CMD_LOOKUP;
        default:   cmd = (r < 33) ? CMD_INSERT : (r < 66) ? CMD_REMOVE : CMD_LOOKUP;
      endcase
    end
    k = $urandom_range(0, POOL_KEYS - 1);
    r = $urandom_range(0, 99);
    if (r < 75) begin
      addr = pool_addr[k];
      uop  = pool_uop[k];
    end else if (r < 80) begin
      // near miss: right address, other micro-op
      addr = pool_addr[k];
      uop  = UOP_W'($urandom);
    end else if (r < 85) begin
      addr = rand_addr();
      uop  = pool_uop[k];
    end else begin
      addr = rand_addr();
      uop  = UOP_W'($urandom);
    end
    return make_item(cmd, addr, uop, HANDLE_W'($urandom), SLOT_W'($urandom));
  endfunction

  initial begin
    mix_mode_e mode;
    rst_ni   <= 1'b0;
    push     <= 1'b0;
    in_item  <= '0;
    tx_burst = 1'b0;
    sb = new();
    foreach (pool_addr[i]) begin
      pool_addr[i] = rand_addr();
      pool_uop[i]  = UOP_W'($urandom);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, field extremes, duplicates, near misses, unused code.
    send_command(make_item(CMD_LOOKUP, '0, 8'h00, 8'h00, 2'd0));
    send_command(make_item(CMD_REMOVE, '1, 8'hff, 8'hff, 2'd3));
    send_command(make_item(CMD_UNUSED, '0, 8'h00, 8'h00, 2'd0));
    send_command(make_item(CMD_INSERT, '0, 8'h00, 8'h00, 2'd0));
    send_command(make_item(CMD_INSERT, '1, 8'hff, 8'hff, 2'd3));
    send_command(make_item(CMD_INSERT, {16{4'h5}}, 8'haa, 8'h55, 2'd1));
    send_command(make_item(CMD_INSERT, {16{4'ha}}, 8'h55, 8'haa, 2'd2));
    send_command(make_item(CMD_LOOKUP, '0, 8'h00, 8'h00, 2'd0));
    send_command(make_item(CMD_LOOKUP, '1, 8'hff, 8'h00, 2'd0));
    send_command(make_item(CMD_LOOKUP, '0, 8'hff, 8'h00, 2'd0));
    send_command(make_item(CMD_LOOKUP, '1, 8'h00, 8'h00, 2'd0));
    send_command(make_item(CMD_INSERT, {16{4'h5}}, 8'haa, 8'h11, 2'd3));
    send_command(make_item(CMD_LOOKUP, {16{4'h5}}, 8'haa, 8'h00, 2'd0));
    send_command(make_item(CMD_REMOVE, {16{4'h5}}, 8'haa, 8'h00, 2'd0));
    send_command(make_item(CMD_LOOKUP, {16{4'h5}}, 8'haa, 8'h00, 2'd0));
    send_command(make_item(CMD_INSERT, 64'h1234, 8'h07, 8'h3c, 2'd1));
    send_command(make_item(CMD_REMOVE, 64'h1235, 8'h07, 8'h00, 2'd0));
    send_command(make_item(CMD_UNUSED, '1, 8'hff, 8'hff, 2'd3));
    send_command(make_item(CMD_REMOVE, '0, 8'h00, 8'h00, 2'd0));
    send_command(make_item(CMD_REMOVE, '1, 8'hff, 8'h00, 2'd0));
    send_command(make_item(CMD_REMOVE, {16{4'h5}}, 8'haa, 8'h00, 2'd0));
    send_command(make_item(CMD_REMOVE, {16{4'ha}}, 8'h55, 8'h00, 2'd0));
    send_command(make_item(CMD_REMOVE, 64'h1234, 8'h07, 8'h00, 2'd0));
    send_command(make_item(CMD_LOOKUP, 64'h1234, 8'h07, 8'h00, 2'd0));

    // Random: segments that push the table toward full, toward empty, or mix.
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg % 6)
        0, 2:    mode = MIX_FILL;
        1:       mode = MIX_MIXED;
        3, 5:    mode = MIX_DRAIN;
        default: mode = MIX_ANY;
      endcase
      tx_burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(0, 19) == 0) begin
          pool_addr[$urandom_range(0, POOL_KEYS - 1)] = rand_addr();
          pool_uop[$urandom_range(0, POOL_KEYS - 1)]  = UOP_W'($urandom);
        end
        send_command(random_command(mode));
      end
    end
    push <= 1'b0;

    while (sb.owed_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.flag_leftovers();
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random pop gaps, bursts, and two long hold-offs to back up the block.
  initial begin
    int unsigned hold_left;
    int unsigned gap_left;
    int unsigned received;
    bit          rx_burst;
    logic        pop_next;
    hold_left = 0;
    gap_left  = 0;
    received  = 0;
    rx_burst  = 1'b0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_left != 0) begin
        hold_left--;
        pop_next = 1'b0;
      end else if (rx_burst) begin
        pop_next = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
        pop_next = 1'b0;
      end else begin
        pop_next = 1'b1;
        gap_left = idle_len();
      end
      pop <= pop_next;
      @(posedge clk_i);
      if (pop && !empty) begin
        sb.check_result(result_o);
        received++;
        if (received == 120 || received == 400) hold_left = HOLD_CYCLES;
        if (received % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      end
    end
  end

  // End the run when no beat moves on either side for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
